@@ sv/vca_pkg.sv @@
// Shared types and constants for the voice channel allocator.
`default_nettype none

package vca_pkg;

  localparam int FUNC_W    = 3;
  localparam int CHAN_IN_W = 5;
  localparam int PRIO_W    = 8;
  localparam int TIME_W    = 32;
  localparam int SND_W     = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_PLAY_AUTO = 3'd0,
    FN_PLAY_CHAN = 3'd1,
    FN_STOP      = 3'd2,
    FN_END       = 3'd3,
    FN_TICK      = 3'd4,
    FN_STOP_ALL  = 3'd5
  } vca_func_e;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] start;
    logic [SND_W-1:0]  snd;
  } vca_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic time_inc;
    logic clear_one;
    logic clear_all;
    logic scan_init;
    logic scan_rd;
    logic look_rd;
    logic commit_auto;
    logic commit_chan;
    logic finish_ok;
    logic finish_fail;
  } vca_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chan_ok;
    logic snd_nz;
    logic scan_last;
  } vca_sts_t;

endpackage

`default_nettype wire

@@ sv/vca_ctrl.sv @@
// Controller state machine for the voice channel allocator.
`default_nettype none

module vca_ctrl
  import vca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [FUNC_W-1:0] func_i,
  input  vca_sts_t          sts_i,
  output logic              busy,
  output vca_cmd_t          cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_DRAIN    = 3'd2;
  localparam logic [2:0] ST_COMMIT_A = 3'd3;
  localparam logic [2:0] ST_LOOK     = 3'd4;
  localparam logic [2:0] ST_COMMIT_C = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FN_PLAY_AUTO: begin
              if (sts_i.snd_nz) begin
                cmd_o.load      = 1'b1;
                cmd_o.time_inc  = 1'b1;
                cmd_o.scan_init = 1'b1;
                state_d         = ST_SCAN;
              end else begin
                cmd_o.finish_fail = 1'b1;
              end
            end
            FN_PLAY_CHAN: begin
              if (sts_i.snd_nz && sts_i.chan_ok) begin
                cmd_o.load     = 1'b1;
                cmd_o.time_inc = 1'b1;
                state_d        = ST_LOOK;
              end else begin
                cmd_o.finish_fail = 1'b1;
              end
            end
            FN_STOP, FN_END: begin
              if (sts_i.chan_ok) begin
                cmd_o.clear_one = 1'b1;
                cmd_o.finish_ok = 1'b1;
              end else begin
                cmd_o.finish_fail = 1'b1;
              end
            end
            FN_TICK: begin
              cmd_o.time_inc  = 1'b1;
              cmd_o.finish_ok = 1'b1;
            end
            FN_STOP_ALL: begin
              cmd_o.clear_all = 1'b1;
              cmd_o.finish_ok = 1'b1;
            end
            default: begin
              cmd_o.finish_fail = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT_A;
      end
      ST_COMMIT_A: begin
        cmd_o.commit_auto = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_LOOK: begin
        cmd_o.look_rd = 1'b1;
        state_d       = ST_COMMIT_C;
      end
      ST_COMMIT_C: begin
        cmd_o.commit_chan = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !sts_i.scan_last) |=> (state_q == ST_SCAN))
    else $error("scan left before the last channel");

  a_drain_to_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (state_q == ST_COMMIT_A))
    else $error("drain not followed by commit");

  a_one_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.commit_auto, cmd_o.commit_chan, cmd_o.finish_ok,
                cmd_o.finish_fail}) <= 1)
    else $error("more than one result in a cycle");
`endif

endmodule

`default_nettype wire

@@ sv/vca_dp.sv @@
// Datapath of the voice channel allocator: channel table, time counter and scan.
`default_nettype none

module vca_dp
  import vca_pkg::*;
#(
  parameter int NUM_CHANNELS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vca_cmd_t             cmd_i,
  output vca_sts_t             sts_o,
  input  logic [CHAN_IN_W-1:0] channel_i,
  input  logic [PRIO_W-1:0]    priority_req_i,
  input  logic [SND_W-1:0]     sound_id_i,
  output logic                 done_o,
  output logic                 ok_o,
  output logic [CHAN_IN_W-1:0] granted_channel_o,
  output logic                 evicted_o,
  output logic [SND_W-1:0]     evicted_sound_o
);

  localparam int CW = $clog2(NUM_CHANNELS);

  // Playing flags live in flops; clearing a channel drops only its flag, not its table entry.
  logic [NUM_CHANNELS-1:0] active_q;
  vca_entry_t              mem_q [NUM_CHANNELS];
  vca_entry_t              rd_data_q;

  logic [TIME_W-1:0] time_q;
  logic [CW-1:0]     chan_q;
  logic [PRIO_W-1:0] prio_q;
  logic [SND_W-1:0]  snd_q;

  logic [CW-1:0] idx_q;
  logic          proc_q;
  logic [CW-1:0] proc_idx_q;
  logic          idle_found_q;
  logic [CW-1:0] idle_idx_q;
  logic          best_found_q;
  logic [CW-1:0] best_idx_q;
  logic [PRIO_W-1:0] best_p_q;
  logic [TIME_W-1:0] best_t_q;
  logic [SND_W-1:0]  best_s_q;

  logic                 done_q;
  logic                 ok_q;
  logic [CHAN_IN_W-1:0] gch_q;
  logic                 ev_q;
  logic [SND_W-1:0]     evs_q;

  logic [CW-1:0] in_idx;
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  vca_entry_t    wr_data;
  logic          auto_ok;
  logic [CW-1:0] auto_pick;
  logic          proc_act;
  logic          better;
  logic          chan_act;

  assign in_idx = CW'(channel_i);

  assign sts_o.chan_ok   = (32'(channel_i) < NUM_CHANNELS);
  assign sts_o.snd_nz    = (sound_id_i != '0);
  assign sts_o.scan_last = (idx_q == CW'(NUM_CHANNELS - 1));

  assign rd_en   = cmd_i.scan_rd || cmd_i.look_rd;
  assign rd_addr = cmd_i.look_rd ? chan_q : idx_q;

  assign auto_ok   = idle_found_q || best_found_q;
  assign auto_pick = idle_found_q ? idle_idx_q : best_idx_q;
  assign chan_act  = active_q[chan_q];

  assign wr_en   = (cmd_i.commit_auto && auto_ok) || cmd_i.commit_chan;
  assign wr_addr = cmd_i.commit_chan ? chan_q : auto_pick;
  assign wr_data = '{prio: prio_q, start: time_q, snd: snd_q};

  assign proc_act = active_q[proc_idx_q];
  // Lower priority wins, then the older start time; ties keep the lower index.
  assign better = (rd_data_q.prio <= prio_q) &&
                  (!best_found_q || (rd_data_q.prio < best_p_q) ||
                   ((rd_data_q.prio == best_p_q) && (rd_data_q.start < best_t_q)));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      chan_q <= in_idx;
      prio_q <= priority_req_i;
      snd_q  <= sound_id_i;
    end
    proc_idx_q <= idx_q;
    if (proc_q && !idle_found_q && !proc_act) begin
      idle_idx_q <= proc_idx_q;
    end
    if (proc_q && better) begin
      best_idx_q <= proc_idx_q;
      best_p_q   <= rd_data_q.prio;
      best_t_q   <= rd_data_q.start;
      best_s_q   <= rd_data_q.snd;
    end
    if (cmd_i.commit_auto) begin
      ok_q  <= auto_ok;
      gch_q <= auto_ok ? CHAN_IN_W'(auto_pick) : '0;
      ev_q  <= !idle_found_q && best_found_q;
      evs_q <= (!idle_found_q && best_found_q) ? best_s_q : '0;
    end else if (cmd_i.commit_chan) begin
      ok_q  <= 1'b1;
      gch_q <= CHAN_IN_W'(chan_q);
      ev_q  <= chan_act;
      evs_q <= chan_act ? rd_data_q.snd : '0;
    end else if (cmd_i.finish_ok || cmd_i.finish_fail) begin
      ok_q  <= cmd_i.finish_ok;
      gch_q <= '0;
      ev_q  <= 1'b0;
      evs_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= '0;
      time_q       <= '0;
      idx_q        <= '0;
      proc_q       <= 1'b0;
      idle_found_q <= 1'b0;
      best_found_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.commit_auto || cmd_i.commit_chan ||
                cmd_i.finish_ok || cmd_i.finish_fail;
      proc_q <= cmd_i.scan_rd;
      if (cmd_i.time_inc) begin
        time_q <= time_q + 1'b1;
      end
      if (cmd_i.scan_init) begin
        idx_q        <= '0;
        idle_found_q <= 1'b0;
        best_found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          idx_q <= idx_q + 1'b1;
        end
        if (proc_q && !proc_act) begin
          idle_found_q <= 1'b1;
        end
        if (proc_q && better) begin
          best_found_q <= 1'b1;
        end
      end
      if (cmd_i.clear_all) begin
        active_q <= '0;
      end else if (cmd_i.clear_one) begin
        active_q[in_idx] <= 1'b0;
      end else if (wr_en) begin
        active_q[wr_addr] <= 1'b1;
      end
    end
  end

  assign done_o            = done_q;
  assign ok_o              = ok_q;
  assign granted_channel_o = gch_q;
  assign evicted_o         = ev_q;
  assign evicted_sound_o   = evs_q;

`ifndef SYNTHESIS
  a_evict_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && ev_q) |-> ok_q)
    else $error("eviction reported on a failed beat");

  a_fail_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !ok_q) |-> (gch_q == '0 && evs_q == '0))
    else $error("failed beat carries data");

  a_stop_all_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_all |=> (active_q == '0))
    else $error("stop all left a channel playing");
`endif

endmodule

`default_nettype wire

@@ sv/voice_channel_allocator.sv @@
// Top level of the voice channel allocator.
// Play auto reads the table once per channel in the scan, then passes drain and commit;
// play on channel reads its own entry, then commits; other commands register their result at accept.
// One item at a time; the next is taken at the edge that ends the result beat, and
// results carry no back pressure on done_o.
// Reset clears all playing flags and the time counter at once; no clearing pass.
`default_nettype none

module voice_channel_allocator
  import vca_pkg::*;
#(
  parameter int NUM_CHANNELS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [CHAN_IN_W-1:0] channel_i,
  input  logic [PRIO_W-1:0]    priority_req_i,
  input  logic [SND_W-1:0]     sound_id_i,
  output logic                 done_o,
  output logic                 ok_o,
  output logic [CHAN_IN_W-1:0] granted_channel_o,
  output logic                 evicted_o,
  output logic [SND_W-1:0]     evicted_sound_o
);

  vca_cmd_t cmd;
  vca_sts_t sts;

  vca_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .sts_i  (sts),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  vca_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .channel_i         (channel_i),
    .priority_req_i    (priority_req_i),
    .sound_id_i        (sound_id_i),
    .done_o            (done_o),
    .ok_o              (ok_o),
    .granted_channel_o (granted_channel_o),
    .evicted_o         (evicted_o),
    .evicted_sound_o   (evicted_sound_o)
  );

endmodule

`default_nettype wire
